[rtl/das_pkg.sv]
// shared types and constants for the daily actuator scheduler
package das_pkg;

    localparam int COUNT_WIDTH = 20;
    localparam int HOUR_WIDTH  = 5;
    localparam int MIN_WIDTH   = 6;
    localparam int PULSE_WIDTH = 20;
    localparam int CFG_WIDTH   = 20;
    localparam int IDX_WIDTH   = 3;
    localparam int IN_WIDTH    = 16;
    localparam int OUT_WIDTH   = 8;

    localparam logic [IDX_WIDTH-1:0] REG_FEED_FIRST_HOUR    = 3'd0;
    localparam logic [IDX_WIDTH-1:0] REG_FEED_FIRST_MINUTE  = 3'd1;
    localparam logic [IDX_WIDTH-1:0] REG_FEED_SECOND_HOUR   = 3'd2;
    localparam logic [IDX_WIDTH-1:0] REG_FEED_SECOND_MINUTE = 3'd3;
    localparam logic [IDX_WIDTH-1:0] REG_CLEAN_HOUR         = 3'd4;
    localparam logic [IDX_WIDTH-1:0] REG_CLEAN_MINUTE       = 3'd5;
    localparam logic [IDX_WIDTH-1:0] REG_PULSE_TICKS        = 3'd6;

    localparam logic [HOUR_WIDTH-1:0]  FEED_FIRST_HOUR_RST    = 5'd6;
    localparam logic [MIN_WIDTH-1:0]   FEED_FIRST_MINUTE_RST  = 6'd0;
    localparam logic [HOUR_WIDTH-1:0]  FEED_SECOND_HOUR_RST   = 5'd18;
    localparam logic [MIN_WIDTH-1:0]   FEED_SECOND_MINUTE_RST = 6'd0;
    localparam logic [HOUR_WIDTH-1:0]  CLEAN_HOUR_RST         = 5'd12;
    localparam logic [MIN_WIDTH-1:0]   CLEAN_MINUTE_RST       = 6'd0;
    localparam logic [PULSE_WIDTH-1:0] PULSE_TICKS_RST        = 20'd5000;

    typedef struct packed {
        logic [HOUR_WIDTH-1:0]  feed_first_hour;
        logic [MIN_WIDTH-1:0]   feed_first_minute;
        logic [HOUR_WIDTH-1:0]  feed_second_hour;
        logic [MIN_WIDTH-1:0]   feed_second_minute;
        logic [HOUR_WIDTH-1:0]  clean_hour;
        logic [MIN_WIDTH-1:0]   clean_minute;
        logic [PULSE_WIDTH-1:0] pulse_ticks;
    } das_cfg_t;

    typedef struct packed {
        logic [HOUR_WIDTH-1:0] clock_hour;
        logic [MIN_WIDTH-1:0]  clock_minute;
        logic                  clock_valid;
        logic                  manual_feed_request;
        logic                  manual_clean_request;
    } das_in_t;

    typedef struct packed {
        logic dispenser_open;
        logic cleaner_on;
        logic feed_is_manual;
        logic clean_is_manual;
        logic feed_rejected;
        logic clean_rejected;
    } das_res_t;

endpackage

[rtl/daily_actuator_scheduler.sv]
// top level of the daily actuator scheduler
//
// each input word is one tick of the time base: clock time, clock-valid bit
// and manual feed and clean requests. each tick yields exactly one output
// word with the dispenser and cleaner drive levels, the manual marks of the
// running pulses and the rejection flags of this tick's manual requests.
// schedule and pulse length are set through the write port (cfg_we,
// cfg_index, cfg_data); the user must write only while the block is idle,
// the block does not enforce it. unknown indexes are ignored. throughput
// is one word per cycle while s_tready is high, set by the single register
// stage around the per-tick logic. a skid stage behind the result register
// lets one more word in while the receiver stalls; s_tready drops only when
// both hold a word. reset clears all channel state and output valids and
// loads the default schedule (06:00, 18:00 feed, 12:00 clean, 5000 ticks).
module daily_actuator_scheduler
    import das_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // clock_hour, clock_minute, clock_valid, manual_feed_request,
    // manual_clean_request, zero fill
    input  logic [IN_WIDTH-1:0]    s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // dispenser_open, cleaner_on, feed_is_manual, clean_is_manual,
    // feed_rejected, clean_rejected, zero fill
    output logic [OUT_WIDTH-1:0]   m_tdata,
    input  logic                   cfg_we,
    input  logic [IDX_WIDTH-1:0]   cfg_index,
    input  logic [CFG_WIDTH-1:0]   cfg_data
);

    das_cfg_t cfg_reg;
    das_in_t  item;
    das_res_t result;
    das_res_t out_word;
    logic     accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.feed_first_hour    <= FEED_FIRST_HOUR_RST;
            cfg_reg.feed_first_minute  <= FEED_FIRST_MINUTE_RST;
            cfg_reg.feed_second_hour   <= FEED_SECOND_HOUR_RST;
            cfg_reg.feed_second_minute <= FEED_SECOND_MINUTE_RST;
            cfg_reg.clean_hour         <= CLEAN_HOUR_RST;
            cfg_reg.clean_minute       <= CLEAN_MINUTE_RST;
            cfg_reg.pulse_ticks        <= PULSE_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FEED_FIRST_HOUR:    cfg_reg.feed_first_hour    <= cfg_data[HOUR_WIDTH-1:0];
                REG_FEED_FIRST_MINUTE:  cfg_reg.feed_first_minute  <= cfg_data[MIN_WIDTH-1:0];
                REG_FEED_SECOND_HOUR:   cfg_reg.feed_second_hour   <= cfg_data[HOUR_WIDTH-1:0];
                REG_FEED_SECOND_MINUTE: cfg_reg.feed_second_minute <= cfg_data[MIN_WIDTH-1:0];
                REG_CLEAN_HOUR:         cfg_reg.clean_hour         <= cfg_data[HOUR_WIDTH-1:0];
                REG_CLEAN_MINUTE:       cfg_reg.clean_minute       <= cfg_data[MIN_WIDTH-1:0];
                REG_PULSE_TICKS:        cfg_reg.pulse_ticks        <= cfg_data[PULSE_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign item.clock_hour           = s_tdata[4:0];
    assign item.clock_minute         = s_tdata[10:5];
    assign item.clock_valid          = s_tdata[11];
    assign item.manual_feed_request  = s_tdata[12];
    assign item.manual_clean_request = s_tdata[13];

    assign accept = s_tvalid && s_tready;

    das_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cfg    (cfg_reg),
        .result (result)
    );

    das_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .result    (result),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word)
    );

    assign m_tdata = {2'b00, out_word.clean_rejected, out_word.feed_rejected,
                      out_word.clean_is_manual, out_word.feed_is_manual,
                      out_word.cleaner_on, out_word.dispenser_open};

endmodule

[rtl/das_core.sv]
// channel state and per-tick scheduling decisions
module das_core
    import das_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  das_in_t  item,
    input  das_cfg_t cfg,
    output das_res_t result
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic                   feed_busy_reg, feed_busy_next;
    logic [COUNT_WIDTH-1:0] feed_elapsed_reg, feed_elapsed_next;
    logic                   feed_first_done_reg, feed_first_done_next;
    logic                   feed_second_done_reg, feed_second_done_next;
    logic                   feed_manual_reg, feed_manual_next;
    logic                   clean_busy_reg, clean_busy_next;
    logic [COUNT_WIDTH-1:0] clean_elapsed_reg, clean_elapsed_next;
    logic                   clean_done_reg, clean_done_next;
    logic                   clean_manual_reg, clean_manual_next;
    logic                   feed_rej, clean_rej;
    logic                   midnight;

    always_comb
    begin
        feed_busy_next        = feed_busy_reg;
        feed_first_done_next  = feed_first_done_reg;
        feed_second_done_next = feed_second_done_reg;
        feed_manual_next      = feed_manual_reg;
        clean_busy_next       = clean_busy_reg;
        clean_done_next       = clean_done_reg;
        clean_manual_next     = clean_manual_reg;
        feed_rej              = 1'b0;
        clean_rej             = 1'b0;
        midnight = (item.clock_hour == '0) && (item.clock_minute == '0);

        // saturating tick counters
        if (feed_busy_reg && (feed_elapsed_reg != COUNT_MAX))
        begin
            feed_elapsed_next = feed_elapsed_reg + 1'b1;
        end
        else
        begin
            feed_elapsed_next = feed_elapsed_reg;
        end
        if (clean_busy_reg && (clean_elapsed_reg != COUNT_MAX))
        begin
            clean_elapsed_next = clean_elapsed_reg + 1'b1;
        end
        else
        begin
            clean_elapsed_next = clean_elapsed_reg;
        end

        // manual requests
        if (item.manual_feed_request)
        begin
            if (!feed_busy_reg)
            begin
                feed_busy_next    = 1'b1;
                feed_elapsed_next = '0;
                feed_manual_next  = 1'b1;
            end
            else
            begin
                feed_rej = 1'b1;
            end
        end
        if (item.manual_clean_request)
        begin
            if (!clean_busy_reg)
            begin
                clean_busy_next    = 1'b1;
                clean_elapsed_next = '0;
                clean_manual_next  = 1'b1;
            end
            else
            begin
                clean_rej = 1'b1;
            end
        end

        // scheduled work
        if (item.clock_valid)
        begin
            if ((item.clock_hour == cfg.feed_first_hour) &&
                (item.clock_minute == cfg.feed_first_minute) &&
                !feed_first_done_next && !feed_busy_next)
            begin
                feed_busy_next       = 1'b1;
                feed_elapsed_next    = '0;
                feed_first_done_next = 1'b1;
            end
            if ((item.clock_hour == cfg.feed_second_hour) &&
                (item.clock_minute == cfg.feed_second_minute) &&
                !feed_second_done_next && !feed_busy_next)
            begin
                feed_busy_next        = 1'b1;
                feed_elapsed_next     = '0;
                feed_second_done_next = 1'b1;
            end
            if (feed_busy_next && (32'(feed_elapsed_next) > 32'(cfg.pulse_ticks)))
            begin
                feed_busy_next   = 1'b0;
                feed_manual_next = 1'b0;
            end
            if (midnight)
            begin
                feed_first_done_next  = 1'b0;
                feed_second_done_next = 1'b0;
            end

            if ((item.clock_hour == cfg.clean_hour) &&
                (item.clock_minute == cfg.clean_minute) &&
                !clean_done_next && !clean_busy_next)
            begin
                clean_busy_next    = 1'b1;
                clean_elapsed_next = '0;
                clean_done_next    = 1'b1;
            end
            if (clean_busy_next && (32'(clean_elapsed_next) > 32'(cfg.pulse_ticks)))
            begin
                clean_busy_next   = 1'b0;
                clean_manual_next = 1'b0;
            end
            if (midnight && clean_done_next && !clean_busy_next)
            begin
                clean_done_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feed_busy_reg        <= 1'b0;
            feed_elapsed_reg     <= '0;
            feed_first_done_reg  <= 1'b0;
            feed_second_done_reg <= 1'b0;
            feed_manual_reg      <= 1'b0;
            clean_busy_reg       <= 1'b0;
            clean_elapsed_reg    <= '0;
            clean_done_reg       <= 1'b0;
            clean_manual_reg     <= 1'b0;
        end
        else if (accept)
        begin
            feed_busy_reg        <= feed_busy_next;
            feed_elapsed_reg     <= feed_elapsed_next;
            feed_first_done_reg  <= feed_first_done_next;
            feed_second_done_reg <= feed_second_done_next;
            feed_manual_reg      <= feed_manual_next;
            clean_busy_reg       <= clean_busy_next;
            clean_elapsed_reg    <= clean_elapsed_next;
            clean_done_reg       <= clean_done_next;
            clean_manual_reg     <= clean_manual_next;
        end
    end

    assign result.dispenser_open  = feed_busy_next;
    assign result.cleaner_on      = clean_busy_next;
    assign result.feed_is_manual  = feed_manual_next;
    assign result.clean_is_manual = clean_manual_next;
    assign result.feed_rejected   = feed_rej;
    assign result.clean_rejected  = clean_rej;

endmodule

[rtl/das_out.sv]
// result register with skid stage
module das_out
    import das_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  das_res_t result,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output das_res_t out_word
);

    logic     out_valid_reg, out_valid_next;
    das_res_t out_word_reg, out_word_next;
    logic     skid_valid_reg, skid_valid_next;
    das_res_t skid_word_reg, skid_word_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        skid_valid_next = skid_valid_reg;
        skid_word_next  = skid_word_reg;
        if (accept)
        begin
            if (!out_valid_reg || out_ready)
            begin
                out_valid_next = 1'b1;
                out_word_next  = result;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_word_next  = result;
            end
        end
        else if (out_valid_reg && out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

[rtl/das_checker.sv]
// port-level checks for the daily actuator scheduler, bound to the top level
module das_checker
    import das_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [OUT_WIDTH-1:0] m_tdata
);

    // stalled word holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // input side only stalls when a word is waiting on the output
    a_ready_back: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // a manual mark only stands on a running pulse
    a_feed_mark: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |-> m_tdata[0])
        else $error("feed manual mark without open dispenser");

    a_clean_mark: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> m_tdata[1])
        else $error("clean manual mark without cleaner on");

    // no word in flight and no accept means the output empties once taken
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && s_tready && !s_tvalid |=> !m_tvalid)
        else $error("output word repeated");

endmodule

bind daily_actuator_scheduler das_checker u_das_checker (.*);
